// ===== src/frema_pkg.sv =====
// Shared types and constants for the frame rate estimator.
// Depends on nothing; imported by frema_serial_div and frame_rate_ema_estimator.
`default_nettype none

package frema_pkg;

   localparam int TIME_W     = 32;
   localparam int RATE_W     = 18;
   localparam int DIVIDEND_W = 22;            // holds 9 * 256000 + 256000
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

   localparam logic [DIVIDEND_W-1:0] RATE_NUMERATOR = DIVIDEND_W'(256000);
   localparam logic [TIME_W-1:0]     BLEND_DIVISOR  = TIME_W'(10);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_INST  = 4'b0010,
      ST_BLEND = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

endpackage

`default_nettype wire

// ===== src/frame_rate_ema_estimator.sv =====
// Frame rate estimator top level: smoothed Q8 frames per second from ms timestamps.
// A first or zero-interval frame publishes the held estimate; else one division gives
// the instantaneous rate, then a blend division if an estimate is already held; each
// retires one quotient bit per cycle (22 steps). One frame is taken at a time.
// Reset (synchronous, active high) clears the held timestamp, estimate and rsp_valid.
// Depends on frema_pkg and frema_serial_div.
`default_nettype none

module frame_rate_ema_estimator
   import frema_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // frame event items
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [TIME_W-1:0] req_frame_time_ms,
   // result items
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [RATE_W-1:0]      rsp_rate_q8,
   output logic                   rsp_rate_updated
);

   state_type           state_ff, state_in;
   logic [TIME_W-1:0]   prev_ff, prev_in;
   logic [RATE_W-1:0]   est_ff, est_in;
   logic                upd_ff, upd_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]   rsp_rate_ff, rsp_rate_in;
   logic                rsp_upd_ff, rsp_upd_in;

   logic                  accept;
   logic [TIME_W-1:0]     interval;
   logic                  div_start;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [TIME_W-1:0]     div_divisor;
   logic                  div_done;
   logic [DIVIDEND_W-1:0] div_quotient;
   logic [DIVIDEND_W-1:0] blend_sum;
   logic                  out_free;

   // Take a new frame only while no item is at work; the result register
   // may still hold the previous answer while the next item runs.
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Interval wraps modulo 2^32.
   assign interval = req_frame_time_ms - prev_ff;

   // 9 * old + inst, formed as (old << 3) + old + inst.
   assign blend_sum = {1'b0, est_ff, 3'b000}
                    + {{(DIVIDEND_W - RATE_W){1'b0}}, est_ff}
                    + div_quotient;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   frema_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in     = state_ff;
      prev_in      = prev_ff;
      est_in       = est_ff;
      upd_in       = upd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_rate_in  = rsp_rate_ff;
      rsp_upd_in   = rsp_upd_ff;
      div_start    = 1'b0;
      div_dividend = RATE_NUMERATOR;
      div_divisor  = interval;

      // Drop the result once the consumer takes it.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // Always store the timestamp; zero means "no frame seen".
               prev_in = req_frame_time_ms;
               if ((prev_ff != '0) && (interval != '0)) begin
                  div_start = 1'b1;
                  state_in  = ST_INST;
               end else begin
                  upd_in   = 1'b0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_INST: begin
            if (div_done) begin
               upd_in = 1'b1;
               if (est_ff == '0) begin
                  // Seed the estimate with the instantaneous rate.
                  est_in   = div_quotient[RATE_W-1:0];
                  state_in = ST_DONE;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = blend_sum;
                  div_divisor  = BLEND_DIVISOR;
                  state_in     = ST_BLEND;
               end
            end
         end
         ST_BLEND: begin
            if (div_done) begin
               est_in   = div_quotient[RATE_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold until the result register is free, then publish.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_rate_in  = est_ff;
               rsp_upd_in   = upd_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_ff      <= '0;
         est_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         est_ff       <= est_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      upd_ff      <= upd_in;
      rsp_rate_ff <= rsp_rate_in;
      rsp_upd_ff  <= rsp_upd_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rate_q8      = rsp_rate_ff;
   assign rsp_rate_updated = rsp_upd_ff;

endmodule

`default_nettype wire

// ===== src/frema_serial_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the rate and blend steps.
// Depends on frema_pkg.
`default_nettype none

module frema_serial_div
   import frema_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [TIME_W-1:0]     divisor,
   output logic                       done,
   output logic [DIVIDEND_W-1:0]      quotient
);

   logic [TIME_W-1:0]     rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [TIME_W-1:0]     dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [TIME_W:0]       trial;
   logic [TIME_W:0]       diff;

   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // load operands, clear remainder
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit, keep the difference when it does not borrow
         if (!diff[TIME_W]) begin
            rem_in = diff[TIME_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[TIME_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire
